@@ src/timestamp_segment_seek_offset_macros.svh @@
`ifndef TIMESTAMP_SEGMENT_SEEK_OFFSET_MACROS_SVH
`define TIMESTAMP_SEGMENT_SEEK_OFFSET_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSSO_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TSSO_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ src/tsso_pkg.sv @@
`timescale 1ns / 1ps
package tsso_pkg;

  localparam int TOKEN_W  = 16;
  localparam int WINDOW_W = 20;
  localparam int STEP_W   = 16;
  localparam int OFFSET_W = 32;
  localparam int REG_IDX_W = 2;
  localparam int SEEN_W   = 2;

  // Register reset values
  localparam logic [TOKEN_W-1:0]  TS_BASE_RST = 16'd50365;
  localparam logic [TOKEN_W-1:0]  END_TOK_RST = 16'd50257;
  localparam logic [WINDOW_W-1:0] WINDOW_RST  = 20'd480000;
  localparam logic [STEP_W-1:0]   STEP_RST    = 16'd320;

  localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_TWO  = 2'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TS_BASE = 2'd0,
    REG_END_TOK = 2'd1,
    REG_WINDOW  = 2'd2,
    REG_STEP    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TOKEN_W-1:0]  ts_base;
    logic [TOKEN_W-1:0]  end_tok;
    logic [WINDOW_W-1:0] window_len;
    logic [STEP_W-1:0]   step;
  } cfg_t;

  // Item held in the input register
  typedef struct packed {
    logic               valid;
    logic [TOKEN_W-1:0] token;
    logic               final_req;
  } stage_t;

endpackage

@@ src/tsso_if.sv @@
`timescale 1ns / 1ps
interface tsso_tok_if;
  logic                        valid;
  logic                        ready;
  logic [tsso_pkg::TOKEN_W-1:0] token;
  logic                        final_req;

  modport source (output valid, output token, output final_req, input ready);
  modport sink   (input valid, input token, input final_req, output ready);
endinterface

interface tsso_res_if;
  logic                          valid;
  logic                          ready;
  logic [tsso_pkg::OFFSET_W-1:0] seek_offset;
  logic                          whole_window;

  modport source (output valid, output seek_offset, output whole_window, input ready);
  modport sink   (input valid, input seek_offset, input whole_window, output ready);
endinterface

interface tsso_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsso_pkg::REG_IDX_W-1:0] reg_index;
  logic [31:0]                    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/tsso_cfg_regs.sv @@
`timescale 1ns / 1ps
module tsso_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  tsso_cfg_if.sink      cfg_ch,
  output tsso_pkg::cfg_t cfg
);
  import tsso_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always take writes
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.reg_index))
        REG_TS_BASE: cfg_nxt.ts_base    = cfg_ch.wdata[TOKEN_W-1:0];
        REG_END_TOK: cfg_nxt.end_tok    = cfg_ch.wdata[TOKEN_W-1:0];
        REG_WINDOW:  cfg_nxt.window_len = cfg_ch.wdata[WINDOW_W-1:0];
        REG_STEP:    cfg_nxt.step       = cfg_ch.wdata[STEP_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ts_base    <= TS_BASE_RST;
      cfg_r.end_tok    <= END_TOK_RST;
      cfg_r.window_len <= WINDOW_RST;
      cfg_r.step       <= STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/tsso_in_stage.sv @@
`timescale 1ns / 1ps
module tsso_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  tsso_tok_if.sink        in_ch,
  input  logic            stage_take,
  output tsso_pkg::stage_t stage
);
  import tsso_pkg::*;

  logic               valid_r;
  logic [TOKEN_W-1:0] token_r;
  logic               final_r;
  logic               load;

  // Load when the register is empty or its item moves on this cycle
  assign in_ch.ready = !valid_r || stage_take;
  assign load        = in_ch.valid && in_ch.ready;
  assign stage       = '{valid: valid_r, token: token_r, final_req: final_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (stage_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      token_r <= in_ch.token;
      final_r <= in_ch.final_req;
    end
  end

endmodule

@@ src/tsso_seek_core.sv @@
`timescale 1ns / 1ps
`include "timestamp_segment_seek_offset_macros.svh"
module tsso_seek_core (
  input  logic             clk,
  input  logic             rst_n,
  input  tsso_pkg::cfg_t   cfg,
  input  tsso_pkg::stage_t stage,
  output logic             stage_take,
  tsso_res_if.source       out_ch
);
  import tsso_pkg::*;

  // Sequence state
  logic [TOKEN_W-1:0] prev_tok_r, prev_tok_nxt;
  logic               prev_stamp_r, prev_stamp_nxt;
  logic               older_stamp_r, older_stamp_nxt;
  logic [SEEN_W-1:0]  seen_r, seen_nxt;
  logic               pair_seen_r, pair_seen_nxt;
  logic [TOKEN_W-1:0] pair_first_r, pair_first_nxt;

  // Result register
  logic                out_valid_r;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                whole_r, whole_nxt;

  logic                push;
  logic                stamp;
  logic                pair_hit;
  logic                single_end;
  logic                emit;
  logic [OFFSET_W-1:0] diff;
  logic [OFFSET_W-1:0] product;

  // Final items need a free result slot; other items only touch state
  assign stage_take = stage.valid && (!stage.final_req || !out_valid_r || out_ch.ready);
  assign emit       = stage_take && stage.final_req;

  // Classify and apply the token (a trailing end token is dropped)
  assign push     = !(stage.final_req && stage.token == cfg.end_tok);
  assign stamp    = stage.token >= cfg.ts_base;
  assign pair_hit = push && seen_r != SEEN_NONE && prev_stamp_r && stamp;

  always_comb begin
    prev_tok_nxt    = prev_tok_r;
    prev_stamp_nxt  = prev_stamp_r;
    older_stamp_nxt = older_stamp_r;
    seen_nxt        = seen_r;
    pair_seen_nxt   = pair_seen_r;
    pair_first_nxt  = pair_first_r;
    if (push) begin
      older_stamp_nxt = prev_stamp_r;
      prev_stamp_nxt  = stamp;
      prev_tok_nxt    = stage.token;
      if (seen_r == SEEN_NONE) begin
        seen_nxt = SEEN_ONE;
      end else begin
        seen_nxt = SEEN_TWO;
      end
    end
    if (pair_hit) begin
      pair_seen_nxt  = 1'b1;
      pair_first_nxt = prev_tok_r;
    end
  end

  // Offset from the updated state, wrapping at 32 bits
  assign single_end = seen_nxt == SEEN_TWO && !older_stamp_nxt && prev_stamp_nxt;
  assign whole_nxt  = !pair_seen_nxt || single_end;
  assign diff       = {{(OFFSET_W-TOKEN_W){1'b0}}, pair_first_nxt}
                    - {{(OFFSET_W-TOKEN_W){1'b0}}, cfg.ts_base};
  assign product    = diff * {{(OFFSET_W-STEP_W){1'b0}}, cfg.step};
  assign offset_nxt = whole_nxt ? {{(OFFSET_W-WINDOW_W){1'b0}}, cfg.window_len} : product;

  // Advance state, clear it after the last token
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      prev_tok_r    <= '0;
      prev_stamp_r  <= 1'b0;
      older_stamp_r <= 1'b0;
      seen_r        <= SEEN_NONE;
      pair_seen_r   <= 1'b0;
      pair_first_r  <= '0;
    end else if (stage_take) begin
      prev_tok_r    <= prev_tok_nxt;
      prev_stamp_r  <= prev_stamp_nxt;
      older_stamp_r <= older_stamp_nxt;
      seen_r        <= seen_nxt;
      pair_seen_r   <= pair_seen_nxt;
      pair_first_r  <= pair_first_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      offset_r <= offset_nxt;
      whole_r  <= whole_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.seek_offset  = offset_r;
  assign out_ch.whole_window = whole_r;

  `TSSO_ASSERT_NEXT(a_clear_after_final, emit, seen_r == SEEN_NONE && !pair_seen_r, "state not cleared after last token")
  `TSSO_ASSERT_NOW(a_seen_saturates, 1'b1, seen_r != 2'd3, "token count beyond saturation")
  `TSSO_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ch.ready, !emit, "result overwritten while stalled")
  `TSSO_ASSERT_NOW(a_pair_needs_two, pair_seen_r, seen_r == SEEN_TWO, "pair recorded with fewer than two tokens")

endmodule

@@ src/timestamp_segment_seek_offset.sv @@
`timescale 1ns / 1ps
// Seek offset from a decoded token stream.
// in_ch: one token per item with final_req marking the last token of a sequence.
// out_ch: one item per sequence, sent for the last token: seek_offset in samples and
//   whole_window, set when the offset is the full window length.
// cfg_ch: register writes (timestamp base, end token, window length, step samples),
//   always ready; write only while no sequence is in flight.
// A result is valid once its last token has passed the input register and then the
//   result register; a stall on out_ch can hold that token in the input register.
// Throughput: one token per cycle unless a last token waits on out_ch; the update
//   is a compare, a subtract and one 32x16 multiply between input and result registers.
// Reset (rst_n low, synchronous): registers return to their defaults, sequence
//   state clears and both channels drain empty.
// Stall: while out_ch is held off, non-final tokens keep flowing; a last token
//   waits in the input register and in_ch.ready drops once it fills.
module timestamp_segment_seek_offset (
  input  logic      clk,
  input  logic      rst_n,
  tsso_tok_if.sink  in_ch,
  tsso_res_if.source out_ch,
  tsso_cfg_if.sink  cfg_ch
);
  import tsso_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   stage_take;

  tsso_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tsso_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .stage_take (stage_take),
    .stage      (stage)
  );

  tsso_seek_core u_seek_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .stage      (stage),
    .stage_take (stage_take),
    .out_ch     (out_ch)
  );

endmodule
